>>> hdl/sfq_pkg.sv
// ----------------------------------------------------------------------------
// sfq_pkg
// Shared types and codes of the switch fabric queue scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package sfq_pkg;

  // Configuration port geometry
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 5;

  // Width of port loop counters; holds any active port count up to eight
  localparam int LCW = 4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MODE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PORTS     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LOOKAHEAD = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_KNOCKOUT  = 3'd4;

  // Scheduling modes
  localparam logic [1:0] MODE_NOQ  = 2'd0;
  localparam logic [1:0] MODE_INQ  = 2'd1;
  localparam logic [1:0] MODE_CIOQ = 2'd2;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ARR,
    ST_NQ_SCAN,
    ST_NQ_CHK,
    ST_NQ_MOD,
    ST_NQ_PICK_RD,
    ST_NQ_PICK,
    ST_LQ_RD,
    ST_LQ_CHK,
    ST_MV,
    ST_MV_SH_RD,
    ST_MV_SH_WR,
    ST_MV_RET,
    ST_CLR,
    ST_TX_RD,
    ST_TX
  } sfq_state_e;

endpackage

`default_nettype wire

>>> hdl/sfq_if.sv
// ----------------------------------------------------------------------------
// sfq_if
// Request and result channels of the switch fabric queue scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

interface sfq_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  arrival_mask;
  logic [23:0] arrival_dest;
  logic [31:0] random_bits;

  modport source (output valid, arrival_mask, arrival_dest, random_bits, input ready);
  modport sink   (input valid, arrival_mask, arrival_dest, random_bits, output ready);
endinterface

interface sfq_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  port;
  logic        transmitted;
  logic [15:0] delay;
  logic [4:0]  output_occupancy;
  logic [4:0]  input_occupancy;
  logic        arrival_dropped;
  logic        knocked_out;
  logic        last;

  modport source (output valid, port, transmitted, delay, output_occupancy,
                  input_occupancy, arrival_dropped, knocked_out, last, input ready);
  modport sink   (input valid, port, transmitted, delay, output_occupancy,
                  input_occupancy, arrival_dropped, knocked_out, last, output ready);
endinterface

`default_nettype wire

>>> hdl/switch_fabric_queue_scheduler_top.sv
// ----------------------------------------------------------------------------
// switch_fabric_queue_scheduler_top
// Cell switch scheduler: per-input FIFOs, per-output FIFOs, one slot per request.
// ----------------------------------------------------------------------------
// Usage:
//  in_i carries one request per time slot: arrival mask, three destination
//  bits per input and one random nibble per output. out_o returns one result
//  per active port, port 0 first, with last set on the highest active port.
//  Configuration is written through cfg_we_i / cfg_idx_i / cfg_data_i while
//  the block is idle; writes take effect at once.
//  A slot runs on one sequencer around two shared queue RAMs (each with one
//  write and one registered read port). It accepts the request, appends the
//  arrivals port by port, then schedules: output queued mode scans the input
//  heads per output, collects the contenders and picks one by the random
//  nibble taken modulo the contender count; the lookahead modes run laps over
//  the inputs, examining the entry at each input's cursor. Each move writes
//  the output queue and shifts the remaining input entries forward, unless
//  the output is full. Then the slot clears and returns one result per active
//  port.
//  in_i.ready is high only between slots; the last result of a slot may still
//  wait in the output register while the next request is accepted.
//  While a held result waits on out_o.ready, it holds and the sequencer waits.
//  Reset empties all queues, clears the slot counter and loads the default
//  configuration; queue RAM contents are never cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module switch_fabric_queue_scheduler_top
  import sfq_pkg::*;
#(
  parameter int PORTS       = 8,
  parameter int QUEUE_DEPTH = 16,
  parameter int STAMP_WIDTH = 16
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  sfq_in_if.sink                     in_i,
  sfq_out_if.source                  out_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int PW   = $clog2(PORTS);
  localparam int QW   = $clog2(QUEUE_DEPTH);
  localparam int CW   = $clog2(QUEUE_DEPTH + 1);
  localparam int AW   = $clog2(PORTS * QUEUE_DEPTH);
  localparam int IQW  = 3 + STAMP_WIDTH;
  localparam int PLIM = (PORTS < 8) ? PORTS : 8;
  localparam int CPW  = (CW > 5) ? CW : 5;

  localparam logic [LCW-1:0] PORT_LIM = LCW'(PLIM);
  localparam logic [AW-1:0]  DEPTH_A  = AW'(QUEUE_DEPTH);
  localparam logic [CW-1:0]  DEPTH_C  = CW'(QUEUE_DEPTH);
  localparam logic [QW:0]    DEPTH_R  = (QW+1)'(QUEUE_DEPTH);

  // Configuration registers
  logic [1:0] mode_q;
  logic [3:0] pin_q;
  logic [4:0] cap_q;
  logic [4:0] look_q;
  logic [3:0] ko_q;

  // Sequencer and slot state
  sfq_state_e             state_q, state_d;
  logic [LCW-1:0]         idx_q, oidx_q, ncnt_q;
  logic [4:0]             lap_q;
  logic [3:0]             rem_q;
  logic [7:0]             mask_q;
  logic [23:0]            dest_q;
  logic [31:0]            rnd_q;
  logic [STAMP_WIDTH-1:0] slot_q;

  // Per-port bookkeeping
  logic [CW-1:0]  in_cnt_q  [PORTS];
  logic [CW-1:0]  out_cnt_q [PORTS];
  logic [QW-1:0]  out_head_q[PORTS];
  logic [CW-1:0]  cursor_q  [PORTS];
  logic [4:0]     sent_q    [PORTS];
  logic [3:0]     kcnt_q    [PORTS];
  logic           drop_q    [PORTS];
  logic [LCW-1:0] cont_q    [PORTS];

  // Move operand registers
  logic [LCW-1:0]         mv_src_q;
  logic [CW-1:0]          mv_pos_q;
  logic [PW-1:0]          mv_dst_q;
  logic [STAMP_WIDTH-1:0] mv_stamp_q;
  logic                   mv_ok_q;

  // Result register
  logic                   res_vld_q;
  logic [2:0]             res_port_q;
  logic                   res_tx_q;
  logic [15:0]            res_delay_q;
  logic [4:0]             res_oocc_q;
  logic [4:0]             res_iocc_q;
  logic                   res_drop_q;
  logic                   res_ko_q;
  logic                   res_last_q;

  // RAM ports
  logic                   iq_we, oq_we;
  logic [AW-1:0]          iq_waddr, iq_raddr, oq_waddr, oq_raddr;
  logic [IQW-1:0]         iq_wdata, iq_rdata;
  logic [STAMP_WIDTH-1:0] oq_wdata, oq_rdata;

  // Effective configuration
  logic [LCW-1:0] p_w;
  logic [CW-1:0]  cap_w;
  logic [4:0]     look_w;
  logic [3:0]     lim_w, klim_w;

  always_comb begin
    if (pin_q == 4'd0) begin
      p_w = LCW'(1);
    end else if (pin_q > PORT_LIM) begin
      p_w = PORT_LIM;
    end else begin
      p_w = pin_q;
    end
    if (cap_q == 5'd0 || CPW'(cap_q) > CPW'(QUEUE_DEPTH)) begin
      cap_w = DEPTH_C;
    end else begin
      cap_w = CW'(cap_q);
    end
    klim_w = (ko_q == 4'd0) ? 4'd1 : ko_q;
    if (mode_q == MODE_CIOQ) begin
      look_w = (look_q == 5'd0) ? 5'd1 : look_q;
      lim_w  = klim_w;
    end else begin
      look_w = 5'd1;
      lim_w  = 4'd1;
    end
  end

  // Selected per-port views
  logic                   mv_state;
  logic [PW-1:0]          in_sel, out_sel, cur_idx;
  logic [CW-1:0]          in_cnt_sel, out_cnt_sel, cursor_sel;
  logic [QW-1:0]          head_sel;
  logic [2:0]             arr_dest, rd_dest;
  logic [STAMP_WIDTH-1:0] rd_stamp;
  logic [4:0]             sent_sel, sent_new;
  logic [LCW-1:0]         pick_src;
  logic [QW:0]            tail_sum, head_inc;
  logic [QW-1:0]          tail_w, head_next;
  logic [CW:0]            pos_inc;
  logic                   idx_done, arr_ok;

  assign mv_state    = (state_q == ST_MV) || (state_q == ST_MV_SH_RD) ||
                       (state_q == ST_MV_SH_WR);
  assign cur_idx     = idx_q[PW-1:0];
  assign in_sel      = mv_state ? mv_src_q[PW-1:0] : cur_idx;
  assign out_sel     = mv_state ? mv_dst_q : cur_idx;
  assign in_cnt_sel  = in_cnt_q[in_sel];
  assign out_cnt_sel = out_cnt_q[out_sel];
  assign head_sel    = out_head_q[out_sel];
  assign cursor_sel  = cursor_q[cur_idx];
  assign arr_dest    = dest_q[3*idx_q[2:0] +: 3];
  assign rd_dest     = iq_rdata[IQW-1 -: 3];
  assign rd_stamp    = iq_rdata[STAMP_WIDTH-1:0];
  assign sent_sel    = sent_q[PW'(rd_dest)];
  assign sent_new    = (sent_sel == 5'd16) ? sent_sel : sent_sel + 5'd1;
  assign pick_src    = cont_q[rem_q[PW-1:0]];
  assign idx_done    = idx_q >= p_w;
  assign arr_ok      = mask_q[idx_q[2:0]] && ({1'b0, arr_dest} < p_w);

  // Ring positions of the output FIFOs
  assign tail_sum  = (QW+1)'(head_sel) + (QW+1)'(out_cnt_sel);
  assign tail_w    = QW'((tail_sum >= DEPTH_R) ? tail_sum - DEPTH_R : tail_sum);
  assign head_inc  = (QW+1)'(head_sel) + (QW+1)'(1);
  assign head_next = QW'((head_inc == DEPTH_R) ? '0 : head_inc);
  assign pos_inc   = (CW+1)'(mv_pos_q) + (CW+1)'(1);

  // Queue RAM addressing
  always_comb begin
    iq_we    = 1'b0;
    iq_waddr = AW'(AW'(cur_idx) * DEPTH_A + AW'(in_cnt_sel));
    iq_wdata = {arr_dest, slot_q};
    iq_raddr = AW'(AW'(cur_idx) * DEPTH_A);
    oq_we    = 1'b0;
    oq_waddr = AW'(AW'(mv_dst_q) * DEPTH_A + AW'(tail_w));
    oq_wdata = mv_stamp_q;
    oq_raddr = AW'(AW'(cur_idx) * DEPTH_A + AW'(head_sel));
    case (state_q)
      ST_ARR: begin
        iq_we = !idx_done && arr_ok && (in_cnt_sel < cap_w);
      end
      ST_NQ_PICK_RD: begin
        iq_raddr = AW'(AW'(pick_src[PW-1:0]) * DEPTH_A);
      end
      ST_LQ_RD: begin
        iq_raddr = AW'(AW'(cur_idx) * DEPTH_A + AW'(cursor_sel));
      end
      ST_MV: begin
        oq_we = out_cnt_sel < cap_w;
      end
      ST_MV_SH_RD: begin
        iq_raddr = AW'(AW'(in_sel) * DEPTH_A + AW'(pos_inc));
      end
      ST_MV_SH_WR: begin
        iq_we    = 1'b1;
        iq_waddr = AW'(AW'(in_sel) * DEPTH_A + AW'(mv_pos_q));
        iq_wdata = iq_rdata;
      end
      default: begin
      end
    endcase
  end

  sfq_ram #(.WIDTH(IQW), .DEPTH(PORTS * QUEUE_DEPTH)) u_in_ram (
    .clk_i   (clk_i),
    .we_i    (iq_we),
    .waddr_i (iq_waddr),
    .wdata_i (iq_wdata),
    .raddr_i (iq_raddr),
    .rdata_o (iq_rdata)
  );

  sfq_ram #(.WIDTH(STAMP_WIDTH), .DEPTH(PORTS * QUEUE_DEPTH)) u_out_ram (
    .clk_i   (clk_i),
    .we_i    (oq_we),
    .waddr_i (oq_waddr),
    .wdata_i (oq_wdata),
    .raddr_i (oq_raddr),
    .rdata_o (oq_rdata)
  );

  logic in_acc, res_space;
  assign in_acc    = in_i.valid && (state_q == ST_IDLE);
  assign res_space = !res_vld_q || out_o.ready;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_i.valid) state_d = ST_ARR;
      end
      ST_ARR: begin
        if (idx_done) state_d = (mode_q == MODE_NOQ) ? ST_NQ_SCAN : ST_LQ_RD;
      end
      ST_NQ_SCAN: begin
        if (oidx_q >= p_w) begin
          state_d = ST_CLR;
        end else if (idx_done) begin
          state_d = (ncnt_q == '0) ? ST_NQ_SCAN : ST_NQ_MOD;
        end else if (in_cnt_sel != '0) begin
          state_d = ST_NQ_CHK;
        end
      end
      ST_NQ_CHK:     state_d = ST_NQ_SCAN;
      ST_NQ_MOD: begin
        if (rem_q < ncnt_q) state_d = ST_NQ_PICK_RD;
      end
      ST_NQ_PICK_RD: state_d = ST_NQ_PICK;
      ST_NQ_PICK:    state_d = ST_MV;
      ST_LQ_RD: begin
        if (idx_done) begin
          if (lap_q + 5'd1 >= look_w) state_d = ST_CLR;
        end else if (cursor_sel < in_cnt_sel) begin
          state_d = ST_LQ_CHK;
        end
      end
      ST_LQ_CHK: begin
        state_d = (sent_new > {1'b0, lim_w}) ? ST_LQ_RD : ST_MV;
      end
      ST_MV: begin
        state_d = (out_cnt_sel < cap_w) ? ST_MV_SH_RD : ST_MV_RET;
      end
      ST_MV_SH_RD: begin
        state_d = (pos_inc < (CW+1)'(in_cnt_sel)) ? ST_MV_SH_WR : ST_MV_RET;
      end
      ST_MV_SH_WR:   state_d = ST_MV_SH_RD;
      ST_MV_RET:     state_d = (mode_q == MODE_NOQ) ? ST_NQ_SCAN : ST_LQ_RD;
      ST_CLR:        state_d = ST_TX_RD;
      ST_TX_RD:      state_d = ST_TX;
      ST_TX: begin
        if (res_space) state_d = (idx_q + LCW'(1) >= p_w) ? ST_IDLE : ST_TX_RD;
      end
      default:       state_d = ST_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_INQ;
      pin_q  <= 4'd8;
      cap_q  <= 5'd4;
      look_q <= 5'd1;
      ko_q   <= 4'd1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MODE:      mode_q <= cfg_data_i[1:0];
        CFG_PORTS:     pin_q  <= cfg_data_i[3:0];
        CFG_CAPACITY:  cap_q  <= cfg_data_i;
        CFG_LOOKAHEAD: look_q <= cfg_data_i;
        CFG_KNOCKOUT:  ko_q   <= cfg_data_i[3:0];
        default: begin
        end
      endcase
    end
  end

  // Queue counts, slot counter and result handshake
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < PORTS; k++) begin
        in_cnt_q[k]   <= '0;
        out_cnt_q[k]  <= '0;
        out_head_q[k] <= '0;
      end
      slot_q    <= '0;
      res_vld_q <= 1'b0;
    end else begin
      if ((state_q == ST_TX) && res_space) begin
        res_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        res_vld_q <= 1'b0;
      end
      case (state_q)
        ST_ARR: begin
          if (iq_we) in_cnt_q[in_sel] <= in_cnt_sel + CW'(1);
        end
        ST_MV: begin
          if (oq_we) out_cnt_q[out_sel] <= out_cnt_sel + CW'(1);
        end
        ST_MV_SH_RD: begin
          if (!(pos_inc < (CW+1)'(in_cnt_sel))) in_cnt_q[in_sel] <= in_cnt_sel - CW'(1);
        end
        ST_CLR: begin
          if (cap_q == 5'd0) begin
            for (int k = 0; k < PORTS; k++) in_cnt_q[k] <= '0;
          end
        end
        ST_TX: begin
          if (res_space) begin
            if (out_cnt_sel != '0) begin
              out_cnt_q[out_sel]  <= out_cnt_sel - CW'(1);
              out_head_q[out_sel] <= head_next;
            end
            if (idx_q + LCW'(1) >= p_w) slot_q <= slot_q + STAMP_WIDTH'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Slot datapath: loop counters, per-slot tallies, move operands, result payload
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          mask_q <= in_i.arrival_mask;
          dest_q <= in_i.arrival_dest;
          rnd_q  <= in_i.random_bits;
          idx_q  <= '0;
          for (int k = 0; k < PORTS; k++) begin
            cursor_q[k] <= '0;
            sent_q[k]   <= '0;
            kcnt_q[k]   <= '0;
            drop_q[k]   <= 1'b0;
          end
        end
      end
      ST_ARR: begin
        if (!idx_done) begin
          if (mask_q[idx_q[2:0]]) begin
            if (!arr_ok) begin
              drop_q[cur_idx] <= 1'b1;
            end else begin
              kcnt_q[PW'(arr_dest)] <= kcnt_q[PW'(arr_dest)] + 4'd1;
              if (in_cnt_sel >= cap_w) drop_q[cur_idx] <= 1'b1;
            end
          end
          idx_q <= idx_q + LCW'(1);
        end else begin
          idx_q  <= '0;
          oidx_q <= '0;
          ncnt_q <= '0;
          lap_q  <= '0;
        end
      end
      ST_NQ_SCAN: begin
        if (oidx_q < p_w) begin
          if (idx_done) begin
            if (ncnt_q == '0) begin
              oidx_q <= oidx_q + LCW'(1);
              idx_q  <= '0;
            end else begin
              rem_q <= rnd_q[4*oidx_q[2:0] +: 4];
            end
          end else if (in_cnt_sel == '0) begin
            idx_q <= idx_q + LCW'(1);
          end
        end
      end
      ST_NQ_CHK: begin
        // collect head-of-line contenders in input order
        if ({1'b0, rd_dest} == oidx_q) begin
          cont_q[ncnt_q[PW-1:0]] <= idx_q;
          ncnt_q <= ncnt_q + LCW'(1);
        end
        idx_q <= idx_q + LCW'(1);
      end
      ST_NQ_MOD: begin
        if (rem_q >= ncnt_q) rem_q <= rem_q - ncnt_q;
      end
      ST_NQ_PICK_RD: begin
        mv_src_q <= pick_src;
        mv_pos_q <= '0;
        mv_dst_q <= PW'(oidx_q);
      end
      ST_NQ_PICK: begin
        mv_stamp_q <= rd_stamp;
      end
      ST_LQ_RD: begin
        if (idx_done) begin
          lap_q <= lap_q + 5'd1;
          idx_q <= '0;
        end else if (cursor_sel >= in_cnt_sel) begin
          idx_q <= idx_q + LCW'(1);
        end
      end
      ST_LQ_CHK: begin
        sent_q[PW'(rd_dest)] <= sent_new;
        if (sent_new > {1'b0, lim_w}) begin
          cursor_q[cur_idx] <= cursor_sel + CW'(1);
          idx_q <= idx_q + LCW'(1);
        end else begin
          mv_src_q   <= idx_q;
          mv_pos_q   <= cursor_sel;
          mv_dst_q   <= PW'(rd_dest);
          mv_stamp_q <= rd_stamp;
        end
      end
      ST_MV: begin
        mv_ok_q <= out_cnt_sel < cap_w;
      end
      ST_MV_SH_WR: begin
        mv_pos_q <= CW'(pos_inc);
      end
      ST_MV_RET: begin
        if (mode_q == MODE_NOQ) begin
          oidx_q <= oidx_q + LCW'(1);
          idx_q  <= '0;
          ncnt_q <= '0;
        end else begin
          if (!mv_ok_q) cursor_q[cur_idx] <= cursor_sel + CW'(1);
          idx_q <= idx_q + LCW'(1);
        end
      end
      ST_CLR: begin
        idx_q <= '0;
      end
      ST_TX: begin
        if (res_space) begin
          res_port_q  <= idx_q[2:0];
          res_tx_q    <= out_cnt_sel != '0;
          res_delay_q <= (out_cnt_sel != '0) ? 16'(slot_q - oq_rdata) : 16'd0;
          res_oocc_q  <= 5'(out_cnt_sel);
          res_iocc_q  <= 5'(in_cnt_sel);
          res_drop_q  <= drop_q[cur_idx];
          res_ko_q    <= (mode_q == MODE_CIOQ) && (kcnt_q[cur_idx] > klim_w);
          res_last_q  <= idx_q + LCW'(1) >= p_w;
          idx_q       <= idx_q + LCW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // Channel outputs
  assign in_i.ready             = state_q == ST_IDLE;
  assign out_o.valid            = res_vld_q;
  assign out_o.port             = res_port_q;
  assign out_o.transmitted      = res_tx_q;
  assign out_o.delay            = res_delay_q;
  assign out_o.output_occupancy = res_oocc_q;
  assign out_o.input_occupancy  = res_iocc_q;
  assign out_o.arrival_dropped  = res_drop_q;
  assign out_o.knocked_out      = res_ko_q;
  assign out_o.last             = res_last_q;

endmodule

`default_nettype wire

>>> hdl/sfq_ram.sv
// ----------------------------------------------------------------------------
// sfq_ram
// Generic simple dual port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sfq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

>>> hdl/sfq_checker.sv
// ----------------------------------------------------------------------------
// sfq_port_checker
// Port-level checks of the switch fabric queue scheduler, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module sfq_port_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_i,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic [2:0]  out_port_i,
  input wire logic        out_tx_i,
  input wire logic [15:0] out_delay_i,
  input wire logic [4:0]  out_oocc_i,
  input wire logic        out_last_i
);

  // A slot in progress blocks the next request
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("request accepted while a slot was still running");

  // A stalled result holds
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_port_i) &&
      $stable(out_last_i))
    else $error("stalled result changed");

  // Mid-slot results only appear while the block is busy
  a_mid_slot_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_last_i |-> !in_ready_i)
    else $error("ready while a slot has results pending");

  // An idle output reports an empty queue and no delay
  a_idle_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_tx_i |-> out_delay_i == 16'd0 && out_oocc_i == 5'd0)
    else $error("idle output reports occupancy or delay");

endmodule

bind switch_fabric_queue_scheduler_top sfq_port_checker u_sfq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_port_i  (out_o.port),
  .out_tx_i    (out_o.transmitted),
  .out_delay_i (out_o.delay),
  .out_oocc_i  (out_o.output_occupancy),
  .out_last_i  (out_o.last)
);

`default_nettype wire

>>> verif/sfq_checker.sv
// ----------------------------------------------------------------------------
// sfq_checker
// Watches the request, result and configuration ports of the scheduler,
// predicts the per-port slot results and compares them in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sfq_checker
  import sfq_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  sfq_in_if                     in_mon,
  sfq_out_if                    out_mon,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int                    fail_count_o,
  output int                    pending_o,
  output int                    checked_o
);

  localparam int NP    = 8;
  localparam int DEPTH = 16;

  typedef struct packed {
    logic [2:0]  port;
    logic        transmitted;
    logic [15:0] delay;
    logic [4:0]  output_occupancy;
    logic [4:0]  input_occupancy;
    logic        arrival_dropped;
    logic        knocked_out;
    logic        last;
  } port_report_t;

  port_report_t expected_reports[$];

  // Shadow configuration
  logic [1:0] sh_mode;
  logic [3:0] sh_ports;
  logic [4:0] sh_cap;
  logic [4:0] sh_look;
  logic [3:0] sh_ko;

  // Shadow queues
  logic [2:0]  iq_dest  [NP][DEPTH];
  logic [15:0] iq_stamp [NP][DEPTH];
  int          iq_cnt   [NP];
  logic [15:0] oq_stamp [NP][DEPTH];
  int          oq_cnt   [NP];
  logic [15:0] slot_ctr;

  assign pending_o = expected_reports.size();

  // Move entry pos of input src to the tail of output dst; 0 when blocked
  function automatic bit move_cell(int src, int pos, int dst, int cap);
    logic [15:0] stamp;
    if (pos >= iq_cnt[src]) return 0;
    if (oq_cnt[dst] >= cap || oq_cnt[dst] >= DEPTH) return 0;
    stamp = iq_stamp[src][pos];
    for (int k = pos; k + 1 < iq_cnt[src]; k++) begin
      iq_dest[src][k]  = iq_dest[src][k+1];
      iq_stamp[src][k] = iq_stamp[src][k+1];
    end
    iq_cnt[src]--;
    oq_stamp[dst][oq_cnt[dst]] = stamp;
    oq_cnt[dst]++;
    return 1;
  endfunction

  // Run one time slot and queue its per-port reports
  task automatic schedule_slot(logic [7:0] mask, logic [23:0] dests, logic [31:0] rnd);
    int p, cap, look, lim, n, r, d, occ;
    int kcount[NP];
    int cursor[NP];
    int contender[NP];
    int sent[NP];
    bit dropped[NP];
    port_report_t rep;
    p = sh_ports;
    if (p == 0) p = 1;
    if (p > NP) p = NP;
    cap = sh_cap;
    if (cap == 0 || cap > DEPTH) cap = DEPTH;
    for (int i = 0; i < NP; i++) begin
      kcount[i] = 0; cursor[i] = 0; sent[i] = 0; dropped[i] = 0;
    end
    // append arrivals, drop on bad destination or full FIFO
    for (int i = 0; i < p; i++) begin
      if (mask[i]) begin
        d = dests[3*i +: 3];
        if (d >= p) begin
          dropped[i] = 1;
        end else begin
          kcount[d]++;
          if (iq_cnt[i] >= cap) begin
            dropped[i] = 1;
          end else begin
            iq_dest[i][iq_cnt[i]]  = d[2:0];
            iq_stamp[i][iq_cnt[i]] = slot_ctr;
            iq_cnt[i]++;
          end
        end
      end
    end
    // schedule
    if (sh_mode == MODE_NOQ) begin
      for (int o = 0; o < p; o++) begin
        n = 0;
        for (int i = 0; i < p; i++)
          if (iq_cnt[i] > 0 && iq_dest[i][0] == o) begin
            contender[n] = i;
            n++;
          end
        if (n != 0) begin
          r = rnd[4*o +: 4] % n;
          void'(move_cell(contender[r], 0, o, cap));
        end
      end
    end else begin
      if (sh_mode == MODE_CIOQ) begin
        look = (sh_look == 0) ? 1 : sh_look;
        lim  = (sh_ko == 0) ? 1 : sh_ko;
      end else begin
        look = 1;
        lim  = 1;
      end
      for (int l = 0; l < look; l++)
        for (int i = 0; i < p; i++) begin
          if (cursor[i] < iq_cnt[i]) begin
            d = iq_dest[i][cursor[i]];
            sent[d]++;
            if (sent[d] > lim) cursor[i]++;
            else if (!move_cell(i, cursor[i], d, cap)) cursor[i]++;
          end
        end
    end
    if (sh_cap == 0)
      for (int i = 0; i < NP; i++) iq_cnt[i] = 0;
    // transmit heads and build reports
    lim = (sh_ko == 0) ? 1 : sh_ko;
    for (int i = 0; i < p; i++) begin
      occ = oq_cnt[i];
      rep = '0;
      rep.port = i[2:0];
      rep.output_occupancy = occ[4:0];
      if (occ > 0) begin
        rep.transmitted = 1'b1;
        rep.delay = slot_ctr - oq_stamp[i][0];
        for (int k = 0; k + 1 < occ; k++) oq_stamp[i][k] = oq_stamp[i][k+1];
        oq_cnt[i] = occ - 1;
      end
      rep.input_occupancy = iq_cnt[i][4:0];
      rep.arrival_dropped = dropped[i];
      rep.knocked_out = (sh_mode == MODE_CIOQ) && (kcount[i] > lim);
      rep.last = (i + 1 == p);
      expected_reports.push_back(rep);
    end
    slot_ctr = slot_ctr + 16'd1;
  endtask

  // Count one mismatch; print it while no more than 40 are counted
  task automatic report(string what, longint got, longint want);
    fail_count_o++;
    if (fail_count_o <= 40)
      $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
  endtask

  // Compare one accepted result with the oldest expectation
  task automatic compare_result();
    port_report_t want;
    checked_o++;
    if (expected_reports.size() == 0) begin
      report("unexpected result, port", out_mon.port, -1);
    end else begin
      want = expected_reports.pop_front();
      if (out_mon.port !== want.port) report("port", out_mon.port, want.port);
      if (out_mon.transmitted !== want.transmitted)
        report("transmitted", out_mon.transmitted, want.transmitted);
      if (out_mon.delay !== want.delay) report("delay", out_mon.delay, want.delay);
      if (out_mon.output_occupancy !== want.output_occupancy)
        report("output_occupancy", out_mon.output_occupancy, want.output_occupancy);
      if (out_mon.input_occupancy !== want.input_occupancy)
        report("input_occupancy", out_mon.input_occupancy, want.input_occupancy);
      if (out_mon.arrival_dropped !== want.arrival_dropped)
        report("arrival_dropped", out_mon.arrival_dropped, want.arrival_dropped);
      if (out_mon.knocked_out !== want.knocked_out)
        report("knocked_out", out_mon.knocked_out, want.knocked_out);
      if (out_mon.last !== want.last) report("last", out_mon.last, want.last);
    end
  endtask

  // Track configuration, requests and results
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sh_mode  <= MODE_INQ;
      sh_ports <= 4'd8;
      sh_cap   <= 5'd4;
      sh_look  <= 5'd1;
      sh_ko    <= 4'd1;
      slot_ctr = '0;
      for (int i = 0; i < NP; i++) begin
        iq_cnt[i] = 0;
        oq_cnt[i] = 0;
      end
      expected_reports.delete();
      fail_count_o <= 0;
      checked_o    <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_MODE:      sh_mode  <= cfg_data_i[1:0];
          CFG_PORTS:     sh_ports <= cfg_data_i[3:0];
          CFG_CAPACITY:  sh_cap   <= cfg_data_i;
          CFG_LOOKAHEAD: sh_look  <= cfg_data_i;
          CFG_KNOCKOUT:  sh_ko    <= cfg_data_i[3:0];
          default: ;
        endcase
      end
      if (out_mon.valid && out_mon.ready) compare_result();
      if (in_mon.valid && in_mon.ready)
        schedule_slot(in_mon.arrival_mask, in_mon.arrival_dest, in_mon.random_bits);
    end
  end

endmodule

>>> verif/switch_fabric_queue_scheduler_top_tb.sv
// ----------------------------------------------------------------------------
// switch_fabric_queue_scheduler_top_tb
// Drives time slots through the scheduler under a series of register
// settings and idle patterns; the checker predicts and compares results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module switch_fabric_queue_scheduler_top_tb;
  import sfq_pkg::*;

  localparam int STALL_LIMIT = 20000;

  logic clk_i;
  logic rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  int fail_count, pending, checked;
  int slots_sent;
  int send_idle_pct, recv_idle_pct;
  int active_ports;
  int stall_cycles;

  sfq_in_if  in_bus ();
  sfq_out_if out_bus ();

  switch_fabric_queue_scheduler_top u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_bus),
    .out_o      (out_bus),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  sfq_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon       (in_bus),
    .out_mon      (out_bus),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  // 20 ns clock
  always begin
    clk_i = 1'b1; #10;
    clk_i = 1'b0; #10;
  end

  // Stall the result side at random
  always @(posedge clk_i) begin
    out_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // End the run when nothing moves for too long
  always @(posedge clk_i) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
      $display("FAIL");
      $finish;
    end
  end

  // Write all five registers while the block is idle
  task automatic program_regs(int m, int p, int cap, int look, int ko);
    logic [CFG_IDX_W-1:0] idx [5];
    int val [5];
    idx = '{CFG_MODE, CFG_PORTS, CFG_CAPACITY, CFG_LOOKAHEAD, CFG_KNOCKOUT};
    val = '{m, p, cap, look, ko};
    for (int k = 0; k < 5; k++) begin
      cfg_we   <= 1'b1;
      cfg_idx  <= idx[k];
      cfg_data <= val[k][CFG_DATA_W-1:0];
      @(posedge clk_i);
    end
    cfg_we <= 1'b0;
    @(posedge clk_i);
    active_ports = (p == 0) ? 1 : (p > 8) ? 8 : p;
  endtask

  // Pick idle rates from how far the run has come
  task automatic set_idling();
    if (slots_sent < 110) begin
      send_idle_pct = 24; recv_idle_pct = 66;
    end else if (slots_sent < 220) begin
      send_idle_pct = 66; recv_idle_pct = 24;
    end else begin
      send_idle_pct = 0; recv_idle_pct = 0;
    end
  endtask

  // Offer one slot request and hold it until accepted
  task automatic send_slot(logic [7:0] mask, logic [23:0] dests, logic [31:0] rnd);
    set_idling();
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_bus.valid        <= 1'b1;
    in_bus.arrival_mask <= mask;
    in_bus.arrival_dest <= dests;
    in_bus.random_bits  <= rnd;
    do @(posedge clk_i); while (!in_bus.ready);
    slots_sent++;
  endtask

  // Mostly legal destinations, some out of range
  task automatic send_random_slots(int n);
    logic [23:0] dests;
    logic [7:0]  mask;
    for (int s = 0; s < n; s++) begin
      for (int i = 0; i < 8; i++)
        dests[3*i +: 3] = 3'(($urandom_range(0, 99) < 85) ? $urandom_range(0, active_ports - 1)
                                                           : $urandom_range(0, 7));
      mask = 8'(($urandom_range(0, 9) == 0) ? 255 : $urandom_range(0, 255));
      send_slot(mask, dests, $urandom());
    end
  endtask

  // Drop valid and let the block drain before touching registers
  task automatic drain();
    in_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  initial begin
    rst_ni       <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_idx      <= '0;
    cfg_data     <= '0;
    in_bus.valid        <= 1'b0;
    in_bus.arrival_mask <= '0;
    in_bus.arrival_dest <= '0;
    in_bus.random_bits  <= '0;
    slots_sent    = 0;
    active_ports  = 8;
    send_idle_pct = 24;
    recv_idle_pct = 66;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: empty slot, full contention, fill and overflow queues
    send_slot(8'h00, 24'h000000, 32'h0);
    send_slot(8'hff, 24'h000000, 32'hffffffff);
    send_slot(8'hff, 24'hffffff, 32'h0);
    send_slot(8'hff, 24'hfac688, 32'h12345678);
    for (int k = 0; k < 5; k++) send_slot(8'hff, 24'h000000, 32'h0);
    send_slot(8'h01, 24'h000007, 32'hffffffff);
    send_slot(8'h80, 24'h000000, 32'h0);
    send_slot(8'h00, 24'h000000, 32'h0);
    drain();

    // Output queued random pick with extreme nibbles
    program_regs(MODE_NOQ, 8, 4, 1, 1);
    send_slot(8'hff, 24'h000000, 32'h0);
    send_slot(8'hff, 24'h000000, 32'hffffffff);
    send_slot(8'hff, 24'h249249, 32'h77777777);
    send_slot(8'hff, 24'hfac688, 32'h89abcdef);
    send_slot(8'hff, 24'hffffff, 32'hffffffff);
    send_slot(8'h00, 24'h000000, 32'h0);
    drain();

    // Random phases over several settings, extremes included
    program_regs(MODE_NOQ, 8, 16, 1, 1);   send_random_slots(40); drain();
    program_regs(MODE_INQ, 4, 2, 1, 1);    send_random_slots(35); drain();
    program_regs(MODE_CIOQ, 8, 0, 16, 8);  send_random_slots(40); drain();
    program_regs(MODE_CIOQ, 3, 1, 3, 2);   send_random_slots(35); drain();
    program_regs(3, 0, 17, 0, 0);          send_random_slots(30); drain();
    program_regs(MODE_NOQ, 15, 31, 5, 15); send_random_slots(35); drain();
    program_regs(MODE_CIOQ, 8, 8, 2, 1);   send_random_slots(40); drain();
    program_regs(MODE_CIOQ, 5, 0, 1, 8);   send_random_slots(30); drain();
    program_regs(MODE_INQ, 8, 4, 1, 1);    send_random_slots(30); drain();
    repeat (200) @(posedge clk_i);

    $display("Ran %0d slots over all three modes and eleven register settings", slots_sent);
    $display("Checked %0d port results, %0d mismatches", checked, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/sfq_pkg.sv
hdl/sfq_if.sv
hdl/sfq_ram.sv
hdl/switch_fabric_queue_scheduler_top.sv
hdl/sfq_checker.sv
verif/sfq_checker.sv
verif/switch_fabric_queue_scheduler_top_tb.sv
